>>> hdl/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types, codes and reset values for the ccTalk host transaction engine.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam int MAX_RESULTS = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // op codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_RX    = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // expected reply kinds
    localparam logic [1:0] REPLY_ACK   = 2'd0;
    localparam logic [1:0] REPLY_FAULT = 2'd1;
    localparam logic [1:0] REPLY_EVENT = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_EVENT = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // finish status
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
    localparam logic [1:0] STATUS_BAD     = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MASTER_ADDR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COIN_ADDR   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BILL_ADDR   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT     = 2'd3;

    // register reset values
    localparam logic [7:0]  RST_MASTER_ADDR = 8'd1;
    localparam logic [7:0]  RST_COIN_ADDR   = 8'd2;
    localparam logic [7:0]  RST_BILL_ADDR   = 8'd40;
    localparam logic [15:0] RST_TIMEOUT     = 16'd100;

    // reply lengths
    localparam logic [4:0] LEN_ACK   = 5'd5;
    localparam logic [4:0] LEN_FAULT = 5'd6;
    localparam logic [4:0] LEN_EVENT = 5'd16;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] dest_address;
        logic [7:0] header;
        logic [1:0] data_count;
        logic [7:0] data_first;
        logic [7:0] data_second;
        logic [1:0] reply_kind;
        logic [7:0] rx_byte;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic [7:0] fault_code;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [7:0]  master_address;
        logic [7:0]  coin_address;
        logic [7:0]  bill_address;
        logic [15:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic                            valid;
        logic [2:0]                      count;
        t_result [MAX_RESULTS-1:0]       res;
    } t_batch;

endpackage

>>> hdl/cct_stream_if.sv
// ----------------------------------------------------------------------------
// cct_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface cct_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/cct_cfg_regs.sv
// ----------------------------------------------------------------------------
// cct_cfg_regs
// Configuration register file, write-only.
// ----------------------------------------------------------------------------
module cct_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cct_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cct_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output cct_pkg::t_cfg                   o_cfg
);

    cct_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.master_address <= cct_pkg::RST_MASTER_ADDR;
            r_cfg.coin_address   <= cct_pkg::RST_COIN_ADDR;
            r_cfg.bill_address   <= cct_pkg::RST_BILL_ADDR;
            r_cfg.timeout_ticks  <= cct_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cct_pkg::REG_MASTER_ADDR: r_cfg.master_address <= i_cfg_data[7:0];
                cct_pkg::REG_COIN_ADDR:   r_cfg.coin_address   <= i_cfg_data[7:0];
                cct_pkg::REG_BILL_ADDR:   r_cfg.bill_address   <= i_cfg_data[7:0];
                cct_pkg::REG_TIMEOUT:     r_cfg.timeout_ticks  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/cct_engine.sv
// ----------------------------------------------------------------------------
// cct_engine
// Input register, exchange state machine and result batch builder.
// ----------------------------------------------------------------------------
module cct_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cct_stream_if.sink      i_cmd,
    input  cct_pkg::t_cfg   i_cfg,
    output cct_pkg::t_batch o_batch,
    input  logic            i_batch_ready
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ECHO,
        PH_REPLY
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [2:0]    r_echo_left, n_echo_left;
    logic [4:0]    r_reply_count, n_reply_count;
    logic [1:0]    r_expected, n_expected;
    logic [7:0]    r_sum, n_sum;
    logic [7:0]    r_source, n_source;
    logic [7:0]    r_header, n_header;
    logic [7:0]    r_fault, n_fault;
    logic [15:0]   r_ticks, n_ticks;

    logic          r_in_valid;
    cct_pkg::t_cmd r_in;
    logic          fire;

    cct_pkg::t_batch batch;

    logic [1:0]    n_data;
    logic [7:0]    frame_sum;
    logic [7:0]    csum;
    logic [2:0]    frame_len;
    logic [7:0]    frame [cct_pkg::MAX_RESULTS];
    logic [15:0]   tick_inc;
    logic [4:0]    need;
    logic          src_ok;
    logic          reply_ok;

    function automatic cct_pkg::t_result mk_res(
        input logic [1:0] kind,
        input logic [7:0] b,
        input logic [1:0] st,
        input logic [7:0] fc,
        input logic       last
    );
        cct_pkg::t_result r;
        r.kind       = kind;
        r.out_byte   = b;
        r.status     = st;
        r.fault_code = fc;
        r.last       = last;
        return r;
    endfunction

    assign fire        = r_in_valid && i_batch_ready;
    assign i_cmd.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
        if (i_cmd.ready && i_cmd.valid) begin
            r_in <= i_cmd.payload;
        end
    end

    // frame assembly
    assign n_data    = (r_in.data_count > 2'd2) ? 2'd2 : r_in.data_count;
    assign frame_sum = r_in.dest_address + {6'd0, n_data} + i_cfg.master_address
                     + r_in.header
                     + ((n_data >= 2'd1) ? r_in.data_first : 8'd0)
                     + ((n_data == 2'd2) ? r_in.data_second : 8'd0);
    assign csum      = 8'd0 - frame_sum;
    assign frame_len = 3'd5 + {1'b0, n_data};

    always_comb begin
        frame[0] = r_in.dest_address;
        frame[1] = {6'd0, n_data};
        frame[2] = i_cfg.master_address;
        frame[3] = r_in.header;
        frame[4] = (n_data >= 2'd1) ? r_in.data_first : csum;
        frame[5] = (n_data == 2'd2) ? r_in.data_second : csum;
        frame[6] = csum;
    end

    assign tick_inc = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 16'd1;
    assign need     = (r_expected == cct_pkg::REPLY_FAULT) ? cct_pkg::LEN_FAULT
                                                           : cct_pkg::LEN_ACK;
    assign src_ok   = (n_source == i_cfg.coin_address) ||
                      (n_source == i_cfg.bill_address);

    always_comb begin
        n_phase       = r_phase;
        n_echo_left   = r_echo_left;
        n_reply_count = r_reply_count;
        n_expected    = r_expected;
        n_sum         = r_sum;
        n_source      = r_source;
        n_header      = r_header;
        n_fault       = r_fault;
        n_ticks       = r_ticks;
        batch         = '0;
        batch.valid   = r_in_valid;
        reply_ok      = 1'b0;

        case (r_in.op)
            cct_pkg::OP_START: begin
                if (r_phase == PH_IDLE) begin
                    for (int i = 0; i < cct_pkg::MAX_RESULTS; i++) begin
                        batch.res[i] = mk_res(cct_pkg::KIND_TX, frame[i],
                                              cct_pkg::STATUS_OK, 8'd0,
                                              3'(i) == frame_len - 3'd1);
                    end
                    batch.count   = frame_len;
                    n_expected    = (r_in.reply_kind > cct_pkg::REPLY_EVENT)
                                  ? cct_pkg::REPLY_ACK : r_in.reply_kind;
                    n_phase       = PH_ECHO;
                    n_echo_left   = frame_len;
                    n_reply_count = 5'd0;
                    n_sum         = 8'd0;
                    n_source      = 8'd0;
                    n_header      = 8'd0;
                    n_fault       = 8'd0;
                    n_ticks       = 16'd0;
                end
            end
            cct_pkg::OP_RX: begin
                if (r_phase == PH_ECHO) begin
                    n_ticks = 16'd0;
                    if (r_echo_left <= 3'd1) begin
                        n_echo_left   = 3'd0;
                        n_phase       = PH_REPLY;
                        n_reply_count = 5'd0;
                        n_sum         = 8'd0;
                    end else begin
                        n_echo_left = r_echo_left - 3'd1;
                    end
                end else if (r_phase == PH_REPLY) begin
                    n_ticks       = 16'd0;
                    n_sum         = r_sum + r_in.rx_byte;
                    n_reply_count = r_reply_count + 5'd1;
                    if (r_reply_count == 5'd2) n_source = r_in.rx_byte;
                    if (r_reply_count == 5'd3) n_header = r_in.rx_byte;
                    if (r_reply_count == 5'd4) n_fault  = r_in.rx_byte;
                    if (r_expected == cct_pkg::REPLY_EVENT) begin
                        if (n_reply_count >= cct_pkg::LEN_EVENT) begin
                            batch.res[0] = mk_res(cct_pkg::KIND_EVENT, r_in.rx_byte,
                                                  cct_pkg::STATUS_OK, 8'd0, 1'b0);
                            batch.res[1] = mk_res(cct_pkg::KIND_DONE, 8'd0,
                                                  cct_pkg::STATUS_OK, 8'd0, 1'b1);
                            batch.count  = 3'd2;
                            n_phase       = PH_IDLE;
                            n_echo_left   = 3'd0;
                            n_reply_count = 5'd0;
                            n_ticks       = 16'd0;
                        end else begin
                            batch.res[0] = mk_res(cct_pkg::KIND_EVENT, r_in.rx_byte,
                                                  cct_pkg::STATUS_OK, 8'd0, 1'b1);
                            batch.count  = 3'd1;
                        end
                    end else if (n_reply_count >= need) begin
                        reply_ok = src_ok && (n_sum == 8'd0);
                        if (r_expected == cct_pkg::REPLY_ACK) begin
                            reply_ok = reply_ok && (n_header == 8'd0);
                        end
                        batch.res[0] = mk_res(cct_pkg::KIND_DONE, 8'd0,
                            reply_ok ? cct_pkg::STATUS_OK : cct_pkg::STATUS_BAD,
                            (reply_ok && r_expected != cct_pkg::REPLY_ACK) ? n_fault
                                                                           : 8'd0,
                            1'b1);
                        batch.count   = 3'd1;
                        n_phase       = PH_IDLE;
                        n_echo_left   = 3'd0;
                        n_reply_count = 5'd0;
                        n_ticks       = 16'd0;
                    end
                end
            end
            cct_pkg::OP_TICK: begin
                if (r_phase != PH_IDLE) begin
                    n_ticks = tick_inc;
                    if (tick_inc >= i_cfg.timeout_ticks) begin
                        batch.res[0] = mk_res(cct_pkg::KIND_DONE, 8'd0,
                                              cct_pkg::STATUS_TIMEOUT, 8'd0, 1'b1);
                        batch.count   = 3'd1;
                        n_phase       = PH_IDLE;
                        n_echo_left   = 3'd0;
                        n_reply_count = 5'd0;
                        n_ticks       = 16'd0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_echo_left   <= 3'd0;
            r_reply_count <= 5'd0;
            r_expected    <= cct_pkg::REPLY_ACK;
            r_sum         <= 8'd0;
            r_source      <= 8'd0;
            r_header      <= 8'd0;
            r_fault       <= 8'd0;
            r_ticks       <= 16'd0;
        end else if (fire) begin
            r_phase       <= n_phase;
            r_echo_left   <= n_echo_left;
            r_reply_count <= n_reply_count;
            r_expected    <= n_expected;
            r_sum         <= n_sum;
            r_source      <= n_source;
            r_header      <= n_header;
            r_fault       <= n_fault;
            r_ticks       <= n_ticks;
        end
    end

    assign o_batch = batch;

endmodule

>>> hdl/cct_res_queue.sv
// ----------------------------------------------------------------------------
// cct_res_queue
// Holds one result batch and shifts it out, one beat per cycle while the
// result sink is ready, through an output register.
// ----------------------------------------------------------------------------
module cct_res_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cct_pkg::t_batch i_batch,
    output logic            o_batch_ready,
    cct_stream_if.source    o_res
);

    cct_pkg::t_result [cct_pkg::MAX_RESULTS-1:0] r_buf;
    logic [2:0]       r_left;
    logic             r_out_valid;
    cct_pkg::t_result r_out;
    logic             move;
    logic             load;

    assign move          = (r_left != 3'd0) && (!r_out_valid || o_res.ready);
    assign o_batch_ready = (i_batch.count == 3'd0) || (r_left == 3'd0) ||
                           ((r_left == 3'd1) && move);
    assign load          = i_batch.valid && o_batch_ready && (i_batch.count != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_left <= i_batch.count;
            end else if (move) begin
                r_left <= r_left - 3'd1;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (load) begin
            r_buf <= i_batch.res;
        end else if (move) begin
            r_buf[cct_pkg::MAX_RESULTS-2:0] <= r_buf[cct_pkg::MAX_RESULTS-1:1];
        end
        if (move) begin
            r_out <= r_buf[0];
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

endmodule

>>> hdl/cctalk_host_transaction_engine.sv
// Host side of a single-wire ccTalk exchange. A start command beat produces
// the command frame (5 to 7 transmit bytes, checksum last); the echo of those
// bytes is dropped, then the reply is checked (ack, fault) or streamed out
// byte by byte (event), ending in one finished beat. A command beat
// waits in the input register until the result queue takes its batch, which
// then moves through the queue buffer and output register; the queue takes
// a new batch only as it sends the last beat of the previous one, one beat
// per cycle while the result sink is ready. Configuration is to be written
// only while no exchange is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
// cctalk_host_transaction_engine
// Top level: configuration registers, exchange engine and result queue.
// ----------------------------------------------------------------------------
module cctalk_host_transaction_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cct_stream_if.sink                      i_cmd,
    cct_stream_if.source                    o_res,
    input  logic                            i_cfg_we,
    input  logic [cct_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cct_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    cct_pkg::t_cfg   cfg;
    cct_pkg::t_batch batch;
    logic            batch_ready;

    cct_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cct_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_cfg         (cfg),
        .o_batch       (batch),
        .i_batch_ready (batch_ready)
    );

    cct_res_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_batch       (batch),
        .o_batch_ready (batch_ready),
        .o_res         (o_res)
    );

endmodule

>>> bench/cctalk_host_transaction_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cctalk_host_transaction_engine_checker
// Watches the command, result and register write ports of the transaction
// engine. It keeps its own copy of the exchange state and the registers,
// predicts the result beats of every accepted command beat, and compares each
// accepted result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cctalk_host_transaction_engine_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  logic                            i_cmd_ready,
    input  cct_pkg::t_cmd                   i_cmd,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  cct_pkg::t_result                i_res,
    input  logic                            i_cfg_we,
    input  logic [cct_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cct_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_errors,
    output int                              o_pending,
    output logic                            o_busy
);
    import cct_pkg::*;

    typedef enum logic [1:0] {XCH_IDLE, XCH_ECHO, XCH_REPLY} t_xch_phase;

    t_cfg        regs;
    t_xch_phase  xch_phase;
    logic [2:0]  echo_left;
    logic [4:0]  reply_count;
    logic [1:0]  want_kind;
    logic [7:0]  reply_sum;
    logic [7:0]  reply_source;
    logic [7:0]  reply_header;
    logic [7:0]  reply_fault;
    logic [15:0] idle_ticks;
    t_result     expected_beats[$];
    int          mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %s: got %0h, expected %0h", name, got, want));
    endtask

    task automatic queue_beat(input logic [1:0] kind, input logic [7:0] b,
                              input logic [1:0] status, input logic [7:0] fc,
                              input logic last);
        t_result r;
        r.kind       = kind;
        r.out_byte   = b;
        r.status     = status;
        r.fault_code = fc;
        r.last       = last;
        expected_beats.push_back(r);
    endtask

    task automatic end_exchange();
        xch_phase   = XCH_IDLE;
        echo_left   = '0;
        reply_count = '0;
        idle_ticks  = '0;
    endtask

    task automatic predict_exchange(input t_cmd c);
        logic [7:0] frame [0:6];
        logic [7:0] sum;
        logic [1:0] n;
        logic [4:0] need;
        logic       ok;
        logic [7:0] fc;
        int         len;
        case (c.op)
            OP_START: begin
                if (xch_phase == XCH_IDLE) begin
                    n = (c.data_count > 2'd2) ? 2'd2 : c.data_count;
                    len = 0;
                    frame[len++] = c.dest_address;
                    frame[len++] = {6'd0, n};
                    frame[len++] = regs.master_address;
                    frame[len++] = c.header;
                    if (n >= 2'd1) frame[len++] = c.data_first;
                    if (n >= 2'd2) frame[len++] = c.data_second;
                    sum = '0;
                    for (int i = 0; i < len; i++) sum = sum + frame[i];
                    frame[len++] = 8'h00 - sum;
                    for (int i = 0; i < len; i++)
                        queue_beat(KIND_TX, frame[i], STATUS_OK, 8'h00, i == len - 1);
                    want_kind    = (c.reply_kind > REPLY_EVENT) ? REPLY_ACK : c.reply_kind;
                    xch_phase    = XCH_ECHO;
                    echo_left    = 3'(len);
                    reply_count  = '0;
                    reply_sum    = '0;
                    reply_source = '0;
                    reply_header = '0;
                    reply_fault  = '0;
                    idle_ticks   = '0;
                end
            end
            OP_RX: begin
                if (xch_phase == XCH_ECHO) begin
                    idle_ticks = '0;
                    if (echo_left > 3'd0) echo_left = echo_left - 3'd1;
                    if (echo_left == 3'd0) begin
                        xch_phase   = XCH_REPLY;
                        reply_count = '0;
                        reply_sum   = '0;
                    end
                end else if (xch_phase == XCH_REPLY) begin
                    idle_ticks = '0;
                    reply_sum  = reply_sum + c.rx_byte;
                    if (reply_count == 5'd2) reply_source = c.rx_byte;
                    if (reply_count == 5'd3) reply_header = c.rx_byte;
                    if (reply_count == 5'd4) reply_fault  = c.rx_byte;
                    reply_count = reply_count + 5'd1;
                    if (want_kind == REPLY_EVENT) begin
                        if (reply_count >= LEN_EVENT) begin
                            queue_beat(KIND_EVENT, c.rx_byte, STATUS_OK, 8'h00, 1'b0);
                            queue_beat(KIND_DONE, 8'h00, STATUS_OK, 8'h00, 1'b1);
                            end_exchange();
                        end else begin
                            queue_beat(KIND_EVENT, c.rx_byte, STATUS_OK, 8'h00, 1'b1);
                        end
                    end else begin
                        need = (want_kind == REPLY_FAULT) ? LEN_FAULT : LEN_ACK;
                        if (reply_count >= need) begin
                            ok = (reply_source == regs.coin_address ||
                                  reply_source == regs.bill_address) && reply_sum == 8'h00;
                            fc = 8'h00;
                            if (want_kind == REPLY_ACK)
                                ok = ok && reply_header == 8'h00;
                            else if (ok)
                                fc = reply_fault;
                            queue_beat(KIND_DONE, 8'h00, ok ? STATUS_OK : STATUS_BAD, fc, 1'b1);
                            end_exchange();
                        end
                    end
                end
            end
            OP_TICK: begin
                if (xch_phase != XCH_IDLE) begin
                    if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
                    if (idle_ticks >= regs.timeout_ticks) begin
                        queue_beat(KIND_DONE, 8'h00, STATUS_TIMEOUT, 8'h00, 1'b1);
                        end_exchange();
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            regs.master_address = RST_MASTER_ADDR;
            regs.coin_address   = RST_COIN_ADDR;
            regs.bill_address   = RST_BILL_ADDR;
            regs.timeout_ticks  = RST_TIMEOUT;
            want_kind    = REPLY_ACK;
            reply_sum    = '0;
            reply_source = '0;
            reply_header = '0;
            reply_fault  = '0;
            end_exchange();
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MASTER_ADDR: regs.master_address = i_cfg_data[7:0];
                    REG_COIN_ADDR:   regs.coin_address   = i_cfg_data[7:0];
                    REG_BILL_ADDR:   regs.bill_address   = i_cfg_data[7:0];
                    REG_TIMEOUT:     regs.timeout_ticks  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing expected: %h", i_res));
                end else begin
                    want = expected_beats.pop_front();
                    check_field("kind", {6'd0, i_res.kind}, {6'd0, want.kind});
                    check_field("out_byte", i_res.out_byte, want.out_byte);
                    check_field("status", {6'd0, i_res.status}, {6'd0, want.status});
                    check_field("fault_code", i_res.fault_code, want.fault_code);
                    check_field("last", {7'd0, i_res.last}, {7'd0, want.last});
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                predict_exchange(i_cmd);
        end
        o_errors  <= mismatches;
        o_pending <= expected_beats.size();
        o_busy    <= (xch_phase != XCH_IDLE);
    end

endmodule

>>> bench/cctalk_host_transaction_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cctalk_host_transaction_engine_tb
// Drives command beats into the transaction engine: a short directed run
// under reset register values, then phases of random exchanges (mostly
// well-formed frames, echoes and replies, some noise and broken exchanges)
// under several register settings, with bursty input and a stalling result
// sink. The checker beside the engine predicts and compares.
// ----------------------------------------------------------------------------
module cctalk_host_transaction_engine_tb;
    import cct_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam logic [1:0] REPLY_UNUSED   = 2'd3;
    localparam int         FRAME_OVERHEAD = 5;
    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         SETTLE_CYCLES  = 16;
    localparam int         LONG_HOLD      = 300;
    localparam int         PHASE_ITEMS    = 44;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     chk_errors;
    int                     chk_pending;
    logic                   chk_busy;
    t_cfg                   cfg_now;
    int                     items_sent  = 0;
    int                     burst_left  = 0;
    int                     cycle_count = 0;
    bit                     long_hold_go = 1'b0;

    cct_stream_if #(.T(t_cmd))    cmd_ch ();
    cct_stream_if #(.T(t_result)) res_ch ();

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    cctalk_host_transaction_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd       (cmd_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cctalk_host_transaction_engine_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd_valid (cmd_ch.valid),
        .i_cmd_ready (cmd_ch.ready),
        .i_cmd       (cmd_ch.payload),
        .i_res_valid (res_ch.valid),
        .i_res_ready (res_ch.ready),
        .i_res       (res_ch.payload),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending),
        .o_busy      (chk_busy)
    );

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cctalk_host_transaction_engine_tb: errors");
            $finish;
        end
    end

    // result sink: rotating stall pattern, one long hold-off on request
    initial begin : result_sink
        logic [7:0] pattern;
        int         pattern_left;
        int         hold_left;
        bit         hold_done;
        pattern      = 8'hFF;
        pattern_left = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (long_hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                res_ch.ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern      = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
                    pattern_left = $urandom_range(32, 128);
                end
                pattern_left--;
                pattern = {pattern[6:0], pattern[7]};
                res_ch.ready <= pattern[7];
            end
        end
    end

    function automatic t_cmd rand_item(input logic [1:0] op);
        logic [63:0] r;
        t_cmd        c;
        r = {$urandom, $urandom};
        c = r[$bits(t_cmd)-1:0];
        c.op = op;
        return c;
    endfunction

    task automatic send_beat(input t_cmd c);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= c;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // bursts of beats with random gaps between them
    task automatic offer(input t_cmd c);
        send_beat(c);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // received byte, sometimes preceded by ticks that stay short of a timeout
    task automatic send_rx(input logic [7:0] b);
        t_cmd c;
        if (cfg_now.timeout_ticks > 16'd1 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, (cfg_now.timeout_ticks > 16'd4) ? 3
                                      : int'(cfg_now.timeout_ticks) - 1))
                offer(rand_item(OP_TICK));
        c = rand_item(OP_RX);
        c.rx_byte = b;
        offer(c);
    endtask

    task automatic send_start(input logic [7:0] dest, input logic [7:0] header,
                              input logic [1:0] count, input logic [7:0] d1,
                              input logic [7:0] d2, input logic [1:0] rkind);
        t_cmd c;
        c = rand_item(OP_START);
        c.dest_address = dest;
        c.header       = header;
        c.data_count   = count;
        c.data_first   = d1;
        c.data_second  = d2;
        c.reply_kind   = rkind;
        offer(c);
    endtask

    task automatic send_reply(input logic [1:0] rkind, input logic [7:0] src,
                              input bit bad_header, input bit bad_sum);
        logic [7:0] b;
        logic [7:0] sum;
        int         rlen;
        rlen = (rkind == REPLY_EVENT) ? int'(LEN_EVENT) :
               (rkind == REPLY_FAULT) ? int'(LEN_FAULT) : int'(LEN_ACK);
        sum = 8'h00;
        for (int i = 0; i < rlen; i++) begin
            b = 8'($urandom);
            if (rkind != REPLY_EVENT) begin
                if (i == 2) b = src;
                if (i == 3 && rkind == REPLY_ACK && !bad_header) b = 8'h00;
                if (i == rlen - 1)
                    b = 8'h00 - sum + (bad_sum ? 8'($urandom_range(1, 255)) : 8'h00);
            end
            sum = sum + b;
            send_rx(b);
        end
    endtask

    // close any open exchange, then wait until every predicted beat is in
    task automatic settle();
        if (cmd_ch.valid) cmd_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (chk_busy) begin
            send_beat(rand_item(OP_RX));
            cmd_ch.valid <= 1'b0;
            repeat (2) @(posedge clk);
        end
        while (chk_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input t_cfg cfg);
        t_cmd       c;
        int         target;
        int         len;
        int         mode;
        logic [1:0] rkind;
        logic [7:0] src;
        cfg_we    <= 1'b1;
        cfg_index <= REG_MASTER_ADDR;
        cfg_data  <= {8'h00, cfg.master_address};
        @(posedge clk);
        cfg_index <= REG_COIN_ADDR;
        cfg_data  <= {8'h00, cfg.coin_address};
        @(posedge clk);
        cfg_index <= REG_BILL_ADDR;
        cfg_data  <= {8'h00, cfg.bill_address};
        @(posedge clk);
        cfg_index <= REG_TIMEOUT;
        cfg_data  <= cfg.timeout_ticks;
        @(posedge clk);
        cfg_we  <= 1'b0;
        cfg_now = cfg;
        target  = items_sent + PHASE_ITEMS;
        while (items_sent < target) begin
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                repeat ($urandom_range(1, 4)) offer(rand_item(2'($urandom_range(0, 3))));
            end else begin
                c = rand_item(OP_START);
                offer(c);
                len   = ((c.data_count > 2'd2) ? 2 : int'(c.data_count)) + FRAME_OVERHEAD;
                rkind = (c.reply_kind == REPLY_UNUSED) ? REPLY_ACK : c.reply_kind;
                if (mode == 1) begin
                    repeat ($urandom_range(0, len + 3)) send_rx(8'($urandom));
                    if (cfg_now.timeout_ticks <= 16'd8)
                        repeat ((cfg_now.timeout_ticks == 16'd0) ? 1
                                : int'(cfg_now.timeout_ticks))
                            offer(rand_item(OP_TICK));
                end else begin
                    repeat (len) send_rx(8'($urandom));
                    case ($urandom_range(0, 7))
                        0, 1, 2: src = cfg_now.coin_address;
                        3, 4, 5: src = cfg_now.bill_address;
                        default: src = 8'($urandom);
                    endcase
                    send_reply(rkind, src, $urandom_range(0, 7) == 0,
                               $urandom_range(0, 7) == 0);
                end
            end
        end
        settle();
    endtask

    initial begin : stimulus
        t_cfg        cfg;
        logic [63:0] r;
        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        cfg_now = t_cfg'{RST_MASTER_ADDR, RST_COIN_ADDR, RST_BILL_ADDR, RST_TIMEOUT};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle noise, max-length frame with unused count and reply kind,
        // start while busy, then a good ack from the bill validator
        send_rx(8'hFF);
        offer(rand_item(OP_TICK));
        offer(rand_item(OP_UNUSED));
        send_start(8'hFF, 8'hFF, 2'd3, 8'hFF, 8'hFF, REPLY_UNUSED);
        send_start(8'h00, 8'h00, 2'd0, 8'h00, 8'h00, REPLY_EVENT);
        for (int i = 0; i < 7; i++) send_rx(i[0] ? 8'hFF : 8'h00);
        send_reply(REPLY_ACK, RST_BILL_ADDR, 1'b0, 1'b0);
        settle();

        run_phase(t_cfg'{8'h00, 8'h00, 8'hFF, 16'd1});
        run_phase(t_cfg'{8'hFF, 8'hFF, 8'h00, 16'hFFFF});
        r = {$urandom, $urandom};
        cfg = r[$bits(t_cfg)-1:0];
        cfg.timeout_ticks = 16'd0;
        run_phase(cfg);
        long_hold_go = 1'b1;
        r = {$urandom, $urandom};
        cfg = r[$bits(t_cfg)-1:0];
        cfg.timeout_ticks = 16'($urandom_range(2, 6));
        run_phase(cfg);
        r = {$urandom, $urandom};
        cfg = r[$bits(t_cfg)-1:0];
        cfg.timeout_ticks = 16'($urandom_range(7, 40));
        run_phase(cfg);

        if (chk_errors == 0 && chk_pending == 0)
            $display("cctalk_host_transaction_engine_tb: clean");
        else
            $display("cctalk_host_transaction_engine_tb: errors");
        $finish;
    end

endmodule

>>> sim.f
hdl/cct_pkg.sv
hdl/cct_stream_if.sv
hdl/cct_cfg_regs.sv
hdl/cct_engine.sv
hdl/cct_res_queue.sv
hdl/cctalk_host_transaction_engine.sv
bench/cctalk_host_transaction_engine_checker.sv
bench/cctalk_host_transaction_engine_tb.sv
